// ===== hw/rtl/bsre_pkg.sv =====
package bsre_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PREF,
    ST_COPY,
    ST_CODE,
    ST_HEAD,
    ST_HI,
    ST_LO
  } bsre_state_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CODE,
    ACT_COPY,
    ACT_LIT
  } bsre_act_e;

  typedef struct packed {
    logic buf_we;
    logic copy_we;
    logic copy_fill;
    logic rd_en;
  } bsre_mem_ctrl_t;

  localparam logic [1:0] REG_FULL = 2'd0;
  localparam logic [1:0] REG_STA  = 2'd1;
  localparam logic [1:0] REG_STB  = 2'd2;

  localparam logic [2:0] KIND_LIT  = 3'd0;
  localparam logic [2:0] KIND_ZERO = 3'd1;
  localparam logic [2:0] KIND_FULL = 3'd2;
  localparam logic [2:0] KIND_STA  = 3'd3;
  localparam logic [2:0] KIND_STB  = 3'd4;

  localparam int unsigned FLAG_ZERO = 0;
  localparam int unsigned FLAG_FULL = 1;
  localparam int unsigned FLAG_STA  = 2;
  localparam int unsigned FLAG_STB  = 3;

  localparam logic [7:0] CHR_LA   = 8'h61;
  localparam logic [7:0] CHR_LB   = 8'h62;
  localparam logic [7:0] CHR_LC   = 8'h63;
  localparam logic [7:0] CHR_LD   = 8'h64;
  localparam logic [7:0] CHR_LE   = 8'h65;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_UA   = 8'h41;

  localparam logic [7:0] FULL_RST = 8'd255;
  localparam logic [7:0] STA_RST  = 8'd34;
  localparam logic [7:0] STB_RST  = 8'd136;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHR_ZERO + {4'h0, v};
    end else begin
      r = CHR_UA + {4'h0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] kind);
    logic [7:0] r;
    case (kind)
      KIND_ZERO: r = CHR_LB;
      KIND_FULL: r = CHR_LC;
      KIND_STA:  r = CHR_LD;
      KIND_STB:  r = CHR_LE;
      default:   r = CHR_LA;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/bsre_if.sv =====
interface bsre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_end;
  logic       page_start;

  modport source (output valid, data_byte, line_end, page_start, input ready);
  modport sink   (input valid, data_byte, line_end, page_start, output ready);
endinterface

interface bsre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] record_kind;
  logic       record_last;

  modport source (output valid, out_char, record_kind, record_last, input ready);
  modport sink   (input valid, out_char, record_kind, record_last, output ready);
endinterface

// ===== hw/rtl/bsre_intake.sv =====
module bsre_intake #(
  parameter int unsigned SEG_BYTES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [7:0]                       data_byte_i,
  input  logic                             line_end_i,
  input  logic                             page_start_i,
  input  logic [7:0]                       full_pattern_i,
  input  logic [7:0]                       stipple_a_i,
  input  logic [7:0]                       stipple_b_i,
  output logic [$clog2(SEG_BYTES)-1:0]     pos_o,
  output bsre_pkg::bsre_act_e              act_o,
  output logic [2:0]                       kind_o,
  output logic [$clog2(SEG_BYTES+1)-1:0]   cnt_o
);

  localparam int unsigned AW = $clog2(SEG_BYTES);
  localparam int unsigned CW = $clog2(SEG_BYTES + 1);

  logic [AW-1:0] fill_q, fill_d;
  logic [3:0]    flags_q, flags_d;
  logic [3:0]    flg;
  logic [CW-1:0] cnt_new;
  logic          seg_full;

  assign pos_o    = page_start_i ? '0 : fill_q;
  assign cnt_new  = CW'(pos_o) + CW'(1);
  assign seg_full = (cnt_new == CW'(SEG_BYTES));
  assign cnt_o    = cnt_new;
  assign flg      = (page_start_i ? 4'hF : flags_q) &
                    {data_byte_i == stipple_b_i, data_byte_i == stipple_a_i,
                     data_byte_i == full_pattern_i, data_byte_i == 8'h00};

  always_comb begin
    act_o  = bsre_pkg::ACT_NONE;
    kind_o = bsre_pkg::KIND_LIT;
    if (seg_full) begin
      if (flg[bsre_pkg::FLAG_ZERO]) begin
        act_o  = bsre_pkg::ACT_CODE;
        kind_o = bsre_pkg::KIND_ZERO;
      end else if (flg[bsre_pkg::FLAG_FULL]) begin
        act_o  = bsre_pkg::ACT_COPY;
        kind_o = bsre_pkg::KIND_FULL;
      end else if (flg[bsre_pkg::FLAG_STA]) begin
        act_o  = bsre_pkg::ACT_COPY;
        kind_o = bsre_pkg::KIND_STA;
      end else if (flg[bsre_pkg::FLAG_STB]) begin
        act_o  = bsre_pkg::ACT_COPY;
        kind_o = bsre_pkg::KIND_STB;
      end else begin
        act_o  = bsre_pkg::ACT_LIT;
      end
    end else if (line_end_i) begin
      act_o = bsre_pkg::ACT_LIT;
    end
  end

  always_comb begin
    fill_d  = fill_q;
    flags_d = flags_q;
    if (accept_i) begin
      if (seg_full || line_end_i) begin
        fill_d  = '0;
        flags_d = 4'hF;
      end else begin
        fill_d  = cnt_new[AW-1:0];
        flags_d = flg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flags_q <= 4'hF;
    end else begin
      fill_q  <= fill_d;
      flags_q <= flags_d;
    end
  end

endmodule

// ===== hw/rtl/bsre_store.sv =====
module bsre_store #(
  parameter int unsigned SEG_BYTES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bsre_pkg::bsre_mem_ctrl_t         ctrl_i,
  input  logic [$clog2(SEG_BYTES)-1:0]     buf_addr_i,
  input  logic [7:0]                       buf_data_i,
  input  logic [$clog2(SEG_BYTES)-1:0]     rd_addr_i,
  input  logic [$clog2(SEG_BYTES)-1:0]     wr_addr_i,
  input  logic [$clog2(SEG_BYTES+1)-1:0]   cnt_i,
  input  logic [7:0]                       fill_byte_i,
  output logic [7:0]                       rd_byte_o
);

  localparam int unsigned CW = $clog2(SEG_BYTES + 1);

  logic [7:0]           buf_mem  [SEG_BYTES];
  logic [7:0]           copy_mem [SEG_BYTES];
  logic [SEG_BYTES-1:0] copy_vld_q;
  logic [7:0]           rd_q;

  // segment bytes first, then the stored copy
  always_ff @(posedge clk_i) begin
    if (ctrl_i.buf_we) begin
      buf_mem[buf_addr_i] <= buf_data_i;
    end
    if (ctrl_i.copy_we) begin
      copy_mem[wr_addr_i] <= ctrl_i.copy_fill ? fill_byte_i : rd_q;
    end
    if (ctrl_i.rd_en) begin
      if (CW'(rd_addr_i) < cnt_i) begin
        rd_q <= buf_mem[rd_addr_i];
      end else if (copy_vld_q[rd_addr_i]) begin
        rd_q <= copy_mem[rd_addr_i];
      end else begin
        rd_q <= 8'hFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_vld_q <= '0;
    end else if (ctrl_i.copy_we) begin
      copy_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_byte_o = rd_q;

endmodule

// ===== hw/rtl/bsre_seq.sv =====
module bsre_seq #(
  parameter int unsigned SEG_BYTES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             page_start_i,
  input  bsre_pkg::bsre_act_e              act_i,
  input  logic [2:0]                       kind_i,
  input  logic [$clog2(SEG_BYTES+1)-1:0]   cnt_i,
  input  logic [7:0]                       rd_byte_i,
  input  logic                             out_ready_i,
  output logic                             ready_o,
  output bsre_pkg::bsre_mem_ctrl_t         ctrl_o,
  output logic [$clog2(SEG_BYTES)-1:0]     rd_addr_o,
  output logic [$clog2(SEG_BYTES)-1:0]     wr_addr_o,
  output logic [$clog2(SEG_BYTES+1)-1:0]   cnt_o,
  output logic                             out_valid_o,
  output logic [7:0]                       out_char_o,
  output logic [2:0]                       out_kind_o,
  output logic                             out_last_o
);

  localparam int unsigned AW = $clog2(SEG_BYTES);
  localparam int unsigned CW = $clog2(SEG_BYTES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(SEG_BYTES - 1);

  bsre_pkg::bsre_state_e state_q, state_d;
  bsre_pkg::bsre_act_e   act_q, act_d;
  logic [2:0]            kind_q, kind_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  ov_q, ov_d;
  logic [7:0]            och_q, och_d;
  logic [2:0]            okind_q, okind_d;
  logic                  olast_q, olast_d;
  logic                  can_load;
  logic                  is_last;
  logic [AW-1:0]         idx_nxt;

  function automatic bsre_pkg::bsre_state_e route(input bsre_pkg::bsre_act_e a);
    bsre_pkg::bsre_state_e s;
    case (a)
      bsre_pkg::ACT_CODE: s = bsre_pkg::ST_CODE;
      bsre_pkg::ACT_COPY: s = bsre_pkg::ST_PREF;
      bsre_pkg::ACT_LIT:  s = bsre_pkg::ST_HEAD;
      default:            s = bsre_pkg::ST_IDLE;
    endcase
    return s;
  endfunction

  assign can_load = !ov_q || out_ready_i;
  assign is_last  = (idx_q == LAST_IDX);
  assign idx_nxt  = is_last ? idx_q : idx_q + AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsre_pkg::ST_IDLE: begin
        if (accept_i) begin
          state_d = page_start_i ? bsre_pkg::ST_FILL : route(act_i);
        end
      end
      bsre_pkg::ST_FILL: begin
        if (is_last) begin
          state_d = route(act_q);
        end
      end
      bsre_pkg::ST_PREF: state_d = bsre_pkg::ST_COPY;
      bsre_pkg::ST_COPY: begin
        if (is_last) begin
          state_d = bsre_pkg::ST_CODE;
        end
      end
      bsre_pkg::ST_CODE: begin
        if (can_load) begin
          state_d = bsre_pkg::ST_IDLE;
        end
      end
      bsre_pkg::ST_HEAD: begin
        if (can_load) begin
          state_d = bsre_pkg::ST_HI;
        end
      end
      bsre_pkg::ST_HI: begin
        if (can_load) begin
          state_d = bsre_pkg::ST_LO;
        end
      end
      bsre_pkg::ST_LO: begin
        if (can_load) begin
          state_d = is_last ? bsre_pkg::ST_IDLE : bsre_pkg::ST_HI;
        end
      end
      default: state_d = bsre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ready_o   = 1'b0;
    ctrl_o    = '0;
    rd_addr_o = idx_q;
    wr_addr_o = idx_q;
    act_d     = act_q;
    kind_d    = kind_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ov_d      = ov_q && !out_ready_i;
    och_d     = och_q;
    okind_d   = okind_q;
    olast_d   = olast_q;
    case (state_q)
      bsre_pkg::ST_IDLE: begin
        ready_o       = 1'b1;
        ctrl_o.buf_we = accept_i;
        if (accept_i) begin
          act_d  = act_i;
          kind_d = kind_i;
          cnt_d  = cnt_i;
          idx_d  = '0;
        end
      end
      bsre_pkg::ST_FILL: begin
        ctrl_o.copy_we   = 1'b1;
        ctrl_o.copy_fill = 1'b1;
        idx_d            = is_last ? '0 : idx_nxt;
      end
      bsre_pkg::ST_PREF: begin
        ctrl_o.rd_en = 1'b1;
        rd_addr_o    = '0;
      end
      bsre_pkg::ST_COPY: begin
        ctrl_o.copy_we = 1'b1;
        ctrl_o.rd_en   = !is_last;
        rd_addr_o      = idx_nxt;
        idx_d          = is_last ? '0 : idx_nxt;
      end
      bsre_pkg::ST_CODE: begin
        if (can_load) begin
          ov_d    = 1'b1;
          och_d   = bsre_pkg::code_char(kind_q);
          okind_d = kind_q;
          olast_d = 1'b1;
        end
      end
      bsre_pkg::ST_HEAD: begin
        if (can_load) begin
          ov_d         = 1'b1;
          och_d        = bsre_pkg::CHR_LA;
          okind_d      = bsre_pkg::KIND_LIT;
          olast_d      = 1'b0;
          ctrl_o.rd_en = 1'b1;
          rd_addr_o    = '0;
          idx_d        = '0;
        end
      end
      bsre_pkg::ST_HI: begin
        if (can_load) begin
          ov_d    = 1'b1;
          och_d   = bsre_pkg::hex_char(rd_byte_i[7:4]);
          okind_d = bsre_pkg::KIND_LIT;
          olast_d = 1'b0;
        end
      end
      bsre_pkg::ST_LO: begin
        if (can_load) begin
          ov_d           = 1'b1;
          och_d          = bsre_pkg::hex_char(rd_byte_i[3:0]);
          okind_d        = bsre_pkg::KIND_LIT;
          olast_d        = is_last;
          ctrl_o.copy_we = 1'b1;
          ctrl_o.rd_en   = !is_last;
          rd_addr_o      = idx_nxt;
          idx_d          = idx_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsre_pkg::ST_IDLE;
      act_q   <= bsre_pkg::ACT_NONE;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    cnt_q   <= cnt_d;
    och_q   <= och_d;
    okind_q <= okind_d;
    olast_q <= olast_d;
  end

  assign cnt_o       = cnt_q;
  assign out_valid_o = ov_q;
  assign out_char_o  = och_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

endmodule

// ===== hw/rtl/bitmap_segment_record_encoder.sv =====
// Channel   Dir  Payload                                  Moves per request
// in_i      in   data_byte[7:0] line_end page_start       one bitmap byte
// out_o     out  out_char[7:0] record_kind[2:0] record_last  one record character
// cfg       in   cfg_we_i cfg_idx_i[1:0] cfg_data_i[7:0]  one register write
//
// A byte with no record leaves the input free again in the next cycle.
// Page start first refills the stored copy; a full, stipple record first
// copies the segment into the stored copy before its character.
// A literal record is 2*SEG_BYTES+1 characters, one per cycle from the output
// register when out_o is ready, set by the single read port of segment stores.
// Reset clears control state; the copy reads as 0xFF until written.
// Output stalls hold the sequencer; input is refused until a record is done.
module bitmap_segment_record_encoder #(
  parameter int unsigned SEG_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  bsre_in_if.sink    in_i,
  bsre_out_if.source out_o
);

  localparam int unsigned AW = $clog2(SEG_BYTES);
  localparam int unsigned CW = $clog2(SEG_BYTES + 1);

  logic [7:0]               full_q, sta_q, stb_q;
  logic                     accept;
  logic                     ready;
  logic [AW-1:0]            pos;
  bsre_pkg::bsre_act_e      act;
  logic [2:0]               kind;
  logic [CW-1:0]            cnt_in, cnt_mem;
  bsre_pkg::bsre_mem_ctrl_t mem_ctrl;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [7:0]               rd_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= bsre_pkg::FULL_RST;
      sta_q  <= bsre_pkg::STA_RST;
      stb_q  <= bsre_pkg::STB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsre_pkg::REG_FULL: full_q <= cfg_data_i;
        bsre_pkg::REG_STA:  sta_q  <= cfg_data_i;
        bsre_pkg::REG_STB:  stb_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept     = in_i.valid && ready;
  assign in_i.ready = ready;

  bsre_intake #(.SEG_BYTES(SEG_BYTES)) u_intake (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_i.data_byte),
    .line_end_i     (in_i.line_end),
    .page_start_i   (in_i.page_start),
    .full_pattern_i (full_q),
    .stipple_a_i    (sta_q),
    .stipple_b_i    (stb_q),
    .pos_o          (pos),
    .act_o          (act),
    .kind_o         (kind),
    .cnt_o          (cnt_in)
  );

  bsre_store #(.SEG_BYTES(SEG_BYTES)) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mem_ctrl),
    .buf_addr_i  (pos),
    .buf_data_i  (in_i.data_byte),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .cnt_i       (cnt_mem),
    .fill_byte_i (full_q),
    .rd_byte_o   (rd_byte)
  );

  bsre_seq #(.SEG_BYTES(SEG_BYTES)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .page_start_i (in_i.page_start),
    .act_i        (act),
    .kind_i       (kind),
    .cnt_i        (cnt_in),
    .rd_byte_i    (rd_byte),
    .out_ready_i  (out_o.ready),
    .ready_o      (ready),
    .ctrl_o       (mem_ctrl),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .cnt_o        (cnt_mem),
    .out_valid_o  (out_o.valid),
    .out_char_o   (out_o.out_char),
    .out_kind_o   (out_o.record_kind),
    .out_last_o   (out_o.record_last)
  );

endmodule
